// ===== hw/rtl/sfc_pkg.sv =====
package sfc_pkg;

    localparam int PLANE_CNT = 6;
    localparam int PLANE_W   = 64;
    localparam int CFG_IDX_W = 3;
    localparam int COORD_W   = 16;
    localparam int NRM_W     = 16;
    localparam int CTR_W     = 17;
    localparam int RAD_W     = 15;
    localparam int PROD_W    = 33;
    localparam int DR_W      = 17;
    localparam int SUM_W     = 36;
    localparam int FRAC_SH   = 14;

    localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR    = 3'd5;

    typedef struct packed {
        logic                     valid;
        logic                     always_vis;
        logic [RAD_W-1:0]         rad;
        logic signed [CTR_W-1:0]  cx;
        logic signed [CTR_W-1:0]  cy;
        logic signed [CTR_W-1:0]  cz;
        logic [PLANE_CNT-1:0]     mask;
    } t_item;

endpackage

// ===== hw/rtl/sphere_frustum_cull.sv =====
// Channel   Direction  Handshake            Payload
// item      in         start high, busy low i_pos_*, i_offset_*, i_sphere_radius,
//                                           i_always_visible
// result    out        o_valid strobe       o_visible, o_outside_mask
// config    in         i_cfg_we             i_cfg_idx, i_cfg_wdata
//
// One item accepted every cycle; busy never rises.
// The result strobe follows acceptance through one entry register, two stages per
// plane cell across six cells, and one output register.
// Synchronous active-low reset clears the planes to zero and the pipeline valids.
// Results cannot be stalled; the pipeline never holds.
module sphere_frustum_cull (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [sfc_pkg::COORD_W-1:0]  i_pos_x,
    input  logic signed [sfc_pkg::COORD_W-1:0]  i_pos_y,
    input  logic signed [sfc_pkg::COORD_W-1:0]  i_pos_z,
    input  logic signed [sfc_pkg::COORD_W-1:0]  i_offset_x,
    input  logic signed [sfc_pkg::COORD_W-1:0]  i_offset_y,
    input  logic signed [sfc_pkg::COORD_W-1:0]  i_offset_z,
    input  logic [sfc_pkg::RAD_W-1:0]           i_sphere_radius,
    input  logic                                i_always_visible,
    input  logic                                i_cfg_we,
    input  logic [sfc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [sfc_pkg::PLANE_W-1:0]         i_cfg_wdata,
    output logic                                o_valid,
    output logic                                o_visible,
    output logic [sfc_pkg::PLANE_CNT-1:0]       o_outside_mask
);
    import sfc_pkg::*;

    t_item                  r_in;
    t_item                  n_in;
    t_item                  chain [0:PLANE_CNT];
    logic [PLANE_CNT-1:0]   cfg_we_vec;
    logic                   r_valid;
    logic                   r_visible;
    logic [PLANE_CNT-1:0]   r_mask;
    t_item                  last;

    assign busy = 1'b0;

    always_comb begin
        cfg_we_vec = '0;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PLANE_LEFT:   cfg_we_vec[0] = 1'b1;
                REG_PLANE_RIGHT:  cfg_we_vec[1] = 1'b1;
                REG_PLANE_BOTTOM: cfg_we_vec[2] = 1'b1;
                REG_PLANE_TOP:    cfg_we_vec[3] = 1'b1;
                REG_PLANE_NEAR:   cfg_we_vec[4] = 1'b1;
                REG_PLANE_FAR:    cfg_we_vec[5] = 1'b1;
                default:          cfg_we_vec    = '0;
            endcase
        end
    end

    always_comb begin
        n_in.valid      = start && !busy;
        n_in.always_vis = i_always_visible;
        n_in.rad        = i_sphere_radius;
        n_in.cx         = CTR_W'(i_pos_x) + CTR_W'(i_offset_x);
        n_in.cy         = CTR_W'(i_pos_y) + CTR_W'(i_offset_y);
        n_in.cz         = CTR_W'(i_pos_z) + CTR_W'(i_offset_z);
        n_in.mask       = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else begin
            r_in <= n_in;
        end
    end

    assign chain[0] = r_in;

    for (genvar g = 0; g < PLANE_CNT; g++) begin : g_cell
        sfc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_we    (cfg_we_vec[g]),
            .i_wdata (i_cfg_wdata),
            .i_item  (chain[g]),
            .o_item  (chain[g+1])
        );
    end

    assign last = chain[PLANE_CNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= last.valid;
        end
        r_visible <= last.always_vis || (last.mask == '0);
        r_mask    <= last.always_vis ? '0 : last.mask;
    end

    assign o_valid        = r_valid;
    assign o_visible      = r_visible;
    assign o_outside_mask = r_mask;

endmodule

// ===== hw/rtl/sfc_cell.sv =====
module sfc_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_we,
    input  logic [sfc_pkg::PLANE_W-1:0] i_wdata,
    input  sfc_pkg::t_item            i_item,
    output sfc_pkg::t_item            o_item
);
    import sfc_pkg::*;

    logic [PLANE_W-1:0]        r_plane;
    t_item                     r_a_item;
    t_item                     r_b_item;
    logic signed [PROD_W-1:0]  r_px;
    logic signed [PROD_W-1:0]  r_py;
    logic signed [PROD_W-1:0]  r_pz;
    logic signed [DR_W-1:0]    r_dr;

    logic signed [NRM_W-1:0]   nx;
    logic signed [NRM_W-1:0]   ny;
    logic signed [NRM_W-1:0]   nz;
    logic signed [COORD_W-1:0] d;
    logic signed [PROD_W-1:0]  n_px;
    logic signed [PROD_W-1:0]  n_py;
    logic signed [PROD_W-1:0]  n_pz;
    logic signed [DR_W-1:0]    n_dr;
    logic signed [SUM_W-1:0]   plane_dist;
    t_item                     n_b_item;

    assign nx = signed'(r_plane[15:0]);
    assign ny = signed'(r_plane[31:16]);
    assign nz = signed'(r_plane[47:32]);
    assign d  = signed'(r_plane[63:48]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (i_we) begin
            r_plane <= i_wdata;
        end
    end

    // stage A: the three products, and d + radius on the same grid
    assign n_px = PROD_W'(nx) * PROD_W'(i_item.cx);
    assign n_py = PROD_W'(ny) * PROD_W'(i_item.cy);
    assign n_pz = PROD_W'(nz) * PROD_W'(i_item.cz);
    assign n_dr = DR_W'(d) + DR_W'(signed'({1'b0, i_item.rad}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_item.valid <= 1'b0;
        end else begin
            r_a_item <= i_item;
        end
        r_px <= n_px;
        r_py <= n_py;
        r_pz <= n_pz;
        r_dr <= n_dr;
    end

    // stage B: outside when n.c + d + r < 0; own bit enters at the top
    assign plane_dist = SUM_W'(r_px) + SUM_W'(r_py) + SUM_W'(r_pz)
                      + (SUM_W'(r_dr) <<< FRAC_SH);

    always_comb begin
        n_b_item      = r_a_item;
        n_b_item.mask = {plane_dist[SUM_W-1], r_a_item.mask[PLANE_CNT-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_item.valid <= 1'b0;
        end else begin
            r_b_item <= n_b_item;
        end
    end

    assign o_item = r_b_item;

endmodule

// ===== hw/rtl/sfc_checker.sv =====
module sfc_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                o_valid,
    input  logic                                o_visible,
    input  logic [sfc_pkg::PLANE_CNT-1:0]       o_outside_mask
);
    import sfc_pkg::*;

    localparam int LAT   = 14;
    localparam int CNT_W = 4;

    logic [CNT_W-1:0] r_since;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since <= '0;
        end else if (r_since != CNT_W'(LAT + 1)) begin
            r_since <= r_since + 1'b1;
        end
    end

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_since == CNT_W'(LAT + 1)) |-> (o_valid == $past(start && !busy, LAT)))
        else $error("result strobe does not follow item by fixed latency");

    a_mask_hides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_outside_mask != '0) |-> !o_visible)
        else $error("visible with outside planes");

    a_hidden_has_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_visible) |-> (o_outside_mask != '0))
        else $error("culled without an outside plane");

endmodule

bind sphere_frustum_cull sfc_checker u_sfc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_visible      (o_visible),
    .o_outside_mask (o_outside_mask)
);

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sfc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
    localparam longint ALIGN = longint'(1) << FRAC_SH;
    localparam logic signed [NRM_W-1:0] NRM_ONE = 16'sd16384;
    localparam int REPORT_MAX = 10;

    typedef struct {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] off_x;
        logic signed [COORD_W-1:0] off_y;
        logic signed [COORD_W-1:0] off_z;
        logic [RAD_W-1:0]          radius;
        logic                      always_vis;
    } t_cull_item;

    typedef struct {
        logic                 visible;
        logic [PLANE_CNT-1:0] mask;
    } t_cull_result;

    class t_cull_scoreboard;
        logic [PLANE_W-1:0] plane_q [PLANE_CNT];
        t_cull_result       verdict_q [$];
        int                 errors;
        int                 visible_cnt;
        int                 culled_cnt;

        function new();
            foreach (plane_q[i]) plane_q[i] = '0;
            errors      = 0;
            visible_cnt = 0;
            culled_cnt  = 0;
        endfunction

        function void set_plane(logic [CFG_IDX_W-1:0] idx, logic [PLANE_W-1:0] val);
            if (idx < PLANE_CNT) plane_q[idx] = val;
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        function void fail(string msg);
            if (errors < REPORT_MAX) $display("%t  %s", $realtime, msg);
            errors++;
        endfunction

        // exact signed distance of the centre to each plane, on the Q.14 grid
        function t_cull_result cull(t_cull_item it);
            longint cx, cy, cz, plane_dist, limit;
            logic signed [NRM_W-1:0] nx, ny, nz, pd;
            t_cull_result r;
            cx = longint'(it.pos_x) + longint'(it.off_x);
            cy = longint'(it.pos_y) + longint'(it.off_y);
            cz = longint'(it.pos_z) + longint'(it.off_z);
            limit = -(longint'(it.radius) * ALIGN);
            r.mask = '0;
            if (!it.always_vis) begin
                for (int i = 0; i < PLANE_CNT; i++) begin
                    nx = plane_q[i][15:0];
                    ny = plane_q[i][31:16];
                    nz = plane_q[i][47:32];
                    pd = plane_q[i][63:48];
                    plane_dist = longint'(nx) * cx + longint'(ny) * cy + longint'(nz) * cz
                               + longint'(pd) * ALIGN;
                    if (plane_dist < limit) r.mask[i] = 1'b1;
                end
            end
            r.visible = it.always_vis || (r.mask == '0);
            return r;
        endfunction

        function void note_item(t_cull_item it);
            verdict_q.insert(verdict_q.size(), cull(it));
        endfunction

        function void check_result(logic vis, logic [PLANE_CNT-1:0] mask);
            t_cull_result want;
            if (verdict_q.size() == 0) begin
                fail($sformatf("unexpected result visible=%b mask=%b", vis, mask));
                return;
            end
            want = verdict_q.pop_front();
            if (vis !== want.visible || mask !== want.mask)
                fail($sformatf("visible %b/%b mask %b/%b (expected/actual)",
                               want.visible, vis, want.mask, mask));
            if (want.visible) visible_cnt++;
            else culled_cnt++;
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic signed [COORD_W-1:0]   i_pos_x, i_pos_y, i_pos_z;
    logic signed [COORD_W-1:0]   i_offset_x, i_offset_y, i_offset_z;
    logic [RAD_W-1:0]            i_sphere_radius;
    logic                        i_always_visible;
    logic                        i_cfg_we;
    logic [CFG_IDX_W-1:0]        i_cfg_idx;
    logic [PLANE_W-1:0]          i_cfg_wdata;
    logic                        o_valid;
    logic                        o_visible;
    logic [PLANE_CNT-1:0]        o_outside_mask;

    t_cull_scoreboard sb = new();
    int sender_idle_pct = 23;
    int box_half = 1000;
    int items_sent = 0;
    int settings_cnt = 0;

    sphere_frustum_cull dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pos_z          (i_pos_z),
        .i_offset_x       (i_offset_x),
        .i_offset_y       (i_offset_y),
        .i_offset_z       (i_offset_z),
        .i_sphere_radius  (i_sphere_radius),
        .i_always_visible (i_always_visible),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_valid          (o_valid),
        .o_visible        (o_visible),
        .o_outside_mask   (o_outside_mask)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1)
            sb.check_result(o_visible, o_outside_mask);
    end

    function automatic logic [CFG_IDX_W-1:0] plane_reg(int p);
        case (p)
            0:       return REG_PLANE_LEFT;
            1:       return REG_PLANE_RIGHT;
            2:       return REG_PLANE_BOTTOM;
            3:       return REG_PLANE_TOP;
            4:       return REG_PLANE_NEAR;
            default: return REG_PLANE_FAR;
        endcase
    endfunction

    function automatic logic [PLANE_W-1:0] pack_plane(logic signed [15:0] nx, ny, nz, d);
        return {d, nz, ny, nx};
    endfunction

    // axis-aligned box: even planes face +axis, odd planes -axis
    function automatic logic [PLANE_W-1:0] box_plane(int p, int half);
        logic signed [NRM_W-1:0] n;
        int axis;
        axis = p / 2;
        n = (p % 2) ? -NRM_ONE : NRM_ONE;
        return pack_plane((axis == 0) ? n : 16'sd0, (axis == 1) ? n : 16'sd0,
                          (axis == 2) ? n : 16'sd0, half[15:0]);
    endfunction

    function automatic t_cull_item mk_item(int px, py, pz, ox, oy, oz, rad, av);
        t_cull_item it;
        it.pos_x = px[15:0];
        it.pos_y = py[15:0];
        it.pos_z = pz[15:0];
        it.off_x = ox[15:0];
        it.off_y = oy[15:0];
        it.off_z = oz[15:0];
        it.radius = rad[14:0];
        it.always_vis = av[0];
        return it;
    endfunction

    function automatic int spread(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic t_cull_item rand_full();
        return mk_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom);
    endfunction

    function automatic t_cull_item rand_item();
        t_cull_item it;
        int sel, p, rad, c, pos;
        sel = $urandom_range(99);
        if (sel < 25) begin
            it = rand_full();
        end else if (sel < 80) begin
            it = mk_item(spread(4000), spread(4000), spread(4000), spread(600),
                         spread(600), spread(600), $urandom_range(1500), 0);
        end else begin
            // centre a few steps either side of touching one box face
            p   = $urandom_range(PLANE_CNT - 1);
            rad = $urandom_range(1500);
            c   = box_half + rad + spread(2);
            if (p % 2 == 0) c = -c;
            pos = spread(1000);
            case (p / 2)
                0:       it = mk_item(pos, 0, 0, c - pos, 0, 0, rad, 0);
                1:       it = mk_item(0, pos, 0, 0, c - pos, 0, rad, 0);
                default: it = mk_item(0, 0, pos, 0, 0, c - pos, rad, 0);
            endcase
        end
        it.always_vis = ($urandom_range(7) == 0);
        return it;
    endfunction

    task automatic drive_fields(t_cull_item it);
        i_pos_x          <= it.pos_x;
        i_pos_y          <= it.pos_y;
        i_pos_z          <= it.pos_z;
        i_offset_x       <= it.off_x;
        i_offset_y       <= it.off_y;
        i_offset_z       <= it.off_z;
        i_sphere_radius  <= it.radius;
        i_always_visible <= it.always_vis;
    endtask

    task automatic send_item(t_cull_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            drive_fields(rand_full());
            @(negedge i_clk);
        end
        start <= 1'b1;
        drive_fields(it);
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic stop_items();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic write_plane(logic [CFG_IDX_W-1:0] idx, logic [PLANE_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.set_plane(idx, val);
    endtask

    task automatic cfg_release();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_cnt++;
    endtask

    task automatic write_box(int half);
        box_half = half;
        for (int p = 0; p < PLANE_CNT; p++) write_plane(plane_reg(p), box_plane(p, half));
    endtask

    initial begin
        logic [PLANE_W-1:0] pv;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_wdata = '0;
        i_pos_x = '0; i_pos_y = '0; i_pos_z = '0;
        i_offset_x = '0; i_offset_y = '0; i_offset_z = '0;
        i_sphere_radius = '0; i_always_visible = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // planes at reset: all zero, everything visible
        send_item(mk_item(32767, 32767, 32767, 32767, 32767, 32767, 0, 0));
        send_item(mk_item(-32768, -32768, -32768, -32768, -32768, -32768, 32767, 0));

        // box of half-width 1000, then writes past the last plane that must be ignored
        stop_items();
        write_box(1000);
        write_plane(REG_SPARE_6, '1);
        write_plane(REG_SPARE_7, 64'h8000_8000_8000_8000);
        cfg_release();
        send_item(mk_item(0, 0, 0, 0, 0, 0, 0, 0));
        for (int p = 0; p < PLANE_CNT; p++) begin
            int c;
            c = (p % 2) ? 1017 : -1017;
            case (p / 2)
                0:       send_item(mk_item(c - 100, 0, 0, 100, 0, 0, 16, 0));
                1:       send_item(mk_item(0, c - 100, 0, 0, 100, 0, 16, 0));
                default: send_item(mk_item(0, 0, c - 100, 0, 0, 100, 16, 0));
            endcase
        end
        send_item(mk_item(-1000, 0, 0, -16, 0, 0, 16, 0));
        send_item(mk_item(0, 0, 1016, 0, 0, 0, 16, 0));
        send_item(mk_item(-32768, -32768, -32768, -32768, -32768, -32768, 0, 1));
        send_item(mk_item(2000, 2000, 2000, 0, 0, 0, 0, 0));
        send_item(mk_item(5000, 5000, 5000, 0, 0, 0, 32767, 0));

        // extreme and unnormalised planes
        stop_items();
        write_plane(REG_PLANE_LEFT,   64'h7FFF_7FFF_7FFF_7FFF);
        write_plane(REG_PLANE_RIGHT,  64'h8000_8000_8000_8000);
        write_plane(REG_PLANE_BOTTOM, '1);
        write_plane(REG_PLANE_TOP,    '0);
        write_plane(REG_PLANE_NEAR,   pack_plane(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF));
        write_plane(REG_PLANE_FAR,    pack_plane(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000));
        cfg_release();
        send_item(mk_item(32767, 32767, 32767, 32767, 32767, 32767, 0, 0));
        send_item(mk_item(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0));
        send_item(mk_item(32767, -32768, 32767, -32768, 32767, -32768, 0, 0));
        send_item(mk_item(32767, 32767, 32767, 32767, 32767, 32767, 32767, 0));
        send_item(mk_item(-32768, -32768, -32768, -32768, -32768, -32768, 32767, 1));

        for (int ph = 0; ph < 6; ph++) begin
            stop_items();
            sender_idle_pct = (ph < 2) ? 23 : (ph < 4) ? 81 : 0;
            case (ph)
                0, 2: write_box($urandom_range(200, 3000));
                4:    write_box(0);
                5: begin
                    for (int p = 0; p < PLANE_CNT; p++) begin
                        case ($urandom_range(4))
                            0:       pv = '0;
                            1:       pv = '1;
                            2:       pv = 64'h7FFF_7FFF_7FFF_7FFF;
                            3:       pv = 64'h8000_8000_8000_8000;
                            default: pv = {$urandom, $urandom};
                        endcase
                        write_plane(plane_reg(p), pv);
                    end
                end
                default: begin
                    for (int p = 0; p < PLANE_CNT; p++)
                        write_plane(plane_reg(p), {$urandom, $urandom});
                end
            endcase
            cfg_release();
            repeat (180) send_item(rand_item());
        end

        stop_items();
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
        if (sb.pending() != 0) sb.fail($sformatf("%0d results never arrived", sb.pending()));
        $display("summary: %0d items over %0d plane settings, %0d visible, %0d culled",
                 items_sent, settings_cnt, sb.visible_cnt, sb.culled_cnt);
        $display("summary: %0d errors", sb.errors);
        if (sb.errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule
